// ===== rtl/windowed_channel_mean_variance_macros.svh =====
// Assertion helpers for the block's top-level RTL file.
`ifndef WINDOWED_CHANNEL_MEAN_VARIANCE_MACROS_SVH
`define WINDOWED_CHANNEL_MEAN_VARIANCE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define WCMV_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define WCMV_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/wcmv_pkg.sv =====
package wcmv_pkg;

   // Default parameter values
   localparam int DEF_CHANNELS          = 16;
   localparam int DEF_MAX_CHUNK_SAMPLES = 1024;
   localparam int DEF_SAMPLE_BITS       = 16;

   // Field and accumulator widths
   localparam int S1_W       = 48;
   localparam int S2_W       = 64;
   localparam int CNT_W      = 32;
   localparam int TIME_W     = 48;
   localparam int SAMPLE_W   = 16;
   localparam int SAMPLE_MAX = 24;
   localparam int MEAN_W     = 32;
   localparam int VAR_W      = 48;
   localparam int CHOUT_W    = 4;
   localparam int CC_W       = 5;
   localparam int SPC_W      = 11;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 48;
   localparam int DIV_W      = 80;
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 88;

   // Opcodes
   localparam logic [1:0] OP_HEADER = 2'd0;
   localparam logic [1:0] OP_CHUNK  = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLES_PER_CHUNK = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_START      = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_END        = 8'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/windowed_channel_mean_variance.sv =====
// Per-channel running mean and population variance over a time-gated sample
// stream. Sums of values and squares live in one single-port-write RAM with one
// entry per channel; a header transfer clears them at once through per-entry
// valid bits. Header and chunk transfers, and samples while the gate is closed,
// are taken in the idle state; a sample while the gate is open reads the RAM,
// then its sums are updated and written back. After the last sample of a gated
// chunk the block emits one result per active channel; each result goes through
// the RAM read and operand load, two passes of the shared 80-bit bit-serial
// divider (mean and mean of squares), and the square, subtract and output steps,
// and waits while the output register stays full. No request is taken until the
// last result has been loaded into the output register.
`include "windowed_channel_mean_variance_macros.svh"
module windowed_channel_mean_variance
   import wcmv_pkg::*;
#(
   parameter int CHANNELS          = DEF_CHANNELS,
   parameter int MAX_CHUNK_SAMPLES = DEF_MAX_CHUNK_SAMPLES,
   parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // opcode[1:0], chunk_start[49:2], chunk_end[97:50], sample_value[113:98]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // channel[3:0], mean[35:4], variance[83:36]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CHN_W  = $clog2(CHANNELS + 1);
   localparam int SP_W   = (MAX_CHUNK_SAMPLES > 1) ? $clog2(MAX_CHUNK_SAMPLES) : 1;
   localparam int NS_W   = $clog2(MAX_CHUNK_SAMPLES + 1);
   localparam int X_W    = SAMPLE_BITS + 1;
   localparam int AX_W   = SAMPLE_BITS;
   localparam int RAM_W  = S1_W + S2_W;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_UPD    = 4'd1;
   localparam logic [3:0] ST_E_RD   = 4'd2;
   localparam logic [3:0] ST_E_LD   = 4'd3;
   localparam logic [3:0] ST_E_MEAN = 4'd4;
   localparam logic [3:0] ST_E_M2   = 4'd5;
   localparam logic [3:0] ST_E_MUL  = 4'd6;
   localparam logic [3:0] ST_E_SUM  = 4'd7;
   localparam logic [3:0] ST_E_VAR  = 4'd8;
   localparam logic [3:0] ST_E_OUT  = 4'd9;

   // Configuration registers
   logic [CC_W-1:0]   cc_ff;
   logic [SPC_W-1:0]  spc_ff;
   logic [TIME_W-1:0] win_start_ff;
   logic [TIME_W-1:0] win_end_ff;

   // Control state
   logic [3:0]        state_ff;
   logic              gate_ff;
   logic [CH_W-1:0]   chan_pos_ff;
   logic [SP_W-1:0]   samp_pos_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CHANNELS-1:0] valid_ff;
   logic              emit_pend_ff;
   logic [CH_W-1:0]   ch_ff;
   logic [CH_W-1:0]   e_ff;

   // Datapath registers
   logic signed [X_W-1:0] x_ff;
   logic [2*AX_W-1:0] sq_ff;
   logic              neg_ff;
   logic [S2_W-1:0]   s2_ff;
   logic [63:0]       m_ff;
   logic [S2_W-1:0]   m2_ff;
   logic [47:0]       hh_ff;
   logic [39:0]       hl_ff;
   logic [31:0]       ll_ff;
   logic              big_ff;
   logic [S2_W-1:0]   q_ff;
   logic [VAR_W-1:0]  var_ff;
   logic [MEAN_W-1:0] mean_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;
   logic              rsp_valid_ff;

   // Request fields
   logic [1:0]        req_op;
   logic [TIME_W-1:0] req_start;
   logic [TIME_W-1:0] req_end;
   logic [SAMPLE_W-1:0] req_sample;

   assign req_op     = req_tdata[1:0];
   assign req_start  = req_tdata[49:2];
   assign req_end    = req_tdata[97:50];
   assign req_sample = req_tdata[113:98];

   // Effective channel and sample counts
   logic [CHN_W-1:0]  nch;
   logic [NS_W-1:0]   ns;
   logic [CH_W-1:0]   ch_cur;
   logic              row_end;
   logic              chunk_end;

   always_comb begin
      if (cc_ff == '0) begin
         nch = CHN_W'(1);
      end else if (32'(cc_ff) > 32'(CHANNELS)) begin
         nch = CHN_W'(CHANNELS);
      end else begin
         nch = CHN_W'(cc_ff);
      end
      if (spc_ff == '0) begin
         ns = NS_W'(1);
      end else if (32'(spc_ff) > 32'(MAX_CHUNK_SAMPLES)) begin
         ns = NS_W'(MAX_CHUNK_SAMPLES);
      end else begin
         ns = NS_W'(spc_ff);
      end
      ch_cur    = (32'(chan_pos_ff) >= 32'(nch)) ? CH_W'(32'(nch) - 32'd1) : chan_pos_ff;
      row_end   = (32'(samp_pos_ff) + 32'd1) >= 32'(ns);
      chunk_end = row_end && ((32'(ch_cur) + 32'd1) >= 32'(nch));
   end

   // Sample sign extension and magnitude
   logic [SAMPLE_MAX-1:0]  raw_ext;
   logic [SAMPLE_BITS-1:0] raw;
   logic signed [X_W-1:0]  x_in;
   logic [AX_W-1:0]        ax;

   always_comb begin
      raw_ext = SAMPLE_MAX'(req_sample);
      raw     = raw_ext[SAMPLE_BITS-1:0];
      x_in    = signed'({raw[SAMPLE_BITS-1], raw});
      ax      = x_in[X_W-1] ? AX_W'(-x_in) : AX_W'(x_in);
   end

   logic req_fire;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Sums RAM
   logic              ram_we;
   logic              ram_re;
   logic [CH_W-1:0]   ram_waddr;
   logic [CH_W-1:0]   ram_raddr;
   logic [RAM_W-1:0]  ram_wdata;
   logic [RAM_W-1:0]  ram_rdata;

   wcmv_ram #(.WIDTH(RAM_W), .DEPTH(CHANNELS)) u_sums (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Entry read: unwritten entries read as zero
   logic [CH_W-1:0]      rd_ch;
   logic signed [S1_W-1:0] s1_old;
   logic [S2_W-1:0]      s2_old;
   logic signed [S1_W:0] s1_sum;
   logic [S2_W:0]        s2_sum;
   logic [S1_W-1:0]      s1_new;
   logic [S2_W-1:0]      s2_new;
   logic [S1_W-1:0]      s1_mag;

   assign rd_ch = (state_ff == ST_UPD) ? ch_ff : e_ff;

   always_comb begin
      s1_old = valid_ff[rd_ch] ? signed'(ram_rdata[S1_W-1:0]) : '0;
      s2_old = valid_ff[rd_ch] ? ram_rdata[RAM_W-1:S1_W] : '0;
      s1_sum = (S1_W+1)'(s1_old) + (S1_W+1)'(x_ff);
      s2_sum = (S2_W+1)'(s2_old) + (S2_W+1)'(sq_ff);
      if (s1_sum[S1_W] != s1_sum[S1_W-1]) begin
         s1_new = s1_sum[S1_W] ? {1'b1, {(S1_W-1){1'b0}}} : {1'b0, {(S1_W-1){1'b1}}};
      end else begin
         s1_new = s1_sum[S1_W-1:0];
      end
      s2_new = s2_sum[S2_W] ? '1 : s2_sum[S2_W-1:0];
      s1_mag = s1_old[S1_W-1] ? S1_W'(-s1_old) : S1_W'(s1_old);
   end

   assign ram_we    = (state_ff == ST_UPD);
   assign ram_waddr = ch_ff;
   assign ram_wdata = {s2_new, s1_new};
   assign ram_re    = (req_fire && (req_op == OP_SAMPLE) && gate_ff) || (state_ff == ST_E_RD);
   assign ram_raddr = (state_ff == ST_E_RD) ? e_ff : ch_cur;

   // Shared divider
   logic               div_start;
   logic [DIV_W-1:0]   div_dividend;
   logic [DIV_W-1:0]   div_quo;
   div_status_type     div_status;

   assign div_start = (state_ff == ST_E_LD) || ((state_ff == ST_E_MEAN) && div_status.done);
   assign div_dividend = (state_ff == ST_E_LD) ? {16'd0, s1_mag, 16'd0}
                                               : {s2_ff, 16'd0};

   wcmv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .quotient (div_quo),
      .status   (div_status)
   );

   // Square of the mean and final variance
   logic [65:0]      qsum;
   logic [S2_W-1:0]  vdiff;
   logic [CNT_W:0]   cnt_sum;
   logic             rsp_free;
   logic             e_last;

   always_comb begin
      qsum     = {2'b0, hh_ff, 16'd0} + 66'({hl_ff, 1'b0}) + 66'(ll_ff[31:16]);
      vdiff    = (m2_ff > q_ff) ? (m2_ff - q_ff) : '0;
      cnt_sum  = (CNT_W+1)'(count_ff) + (CNT_W+1)'(ns);
      rsp_free = !rsp_valid_ff || rsp_tready;
      e_last   = (32'(e_ff) + 32'd1) >= 32'(nch);
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff        <= CC_W'(1);
         spc_ff       <= SPC_W'(32);
         win_start_ff <= '0;
         win_end_ff   <= '1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_CHANNEL_COUNT:     cc_ff        <= csr_data[CC_W-1:0];
            REG_SAMPLES_PER_CHUNK: spc_ff       <= csr_data[SPC_W-1:0];
            REG_WINDOW_START:      win_start_ff <= csr_data[TIME_W-1:0];
            REG_WINDOW_END:        win_end_ff   <= csr_data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gate_ff      <= 1'b0;
         chan_pos_ff  <= '0;
         samp_pos_ff  <= '0;
         count_ff     <= '0;
         valid_ff     <= '0;
         emit_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         e_ff         <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  unique case (req_op)
                     OP_HEADER: begin
                        valid_ff    <= '0;
                        count_ff    <= '0;
                        chan_pos_ff <= '0;
                        samp_pos_ff <= '0;
                     end
                     OP_CHUNK: begin
                        gate_ff     <= (req_start >= win_start_ff) && (req_end <= win_end_ff);
                        chan_pos_ff <= '0;
                        samp_pos_ff <= '0;
                     end
                     OP_SAMPLE: begin
                        ch_ff        <= ch_cur;
                        emit_pend_ff <= chunk_end && gate_ff;
                        if (!row_end) begin
                           samp_pos_ff <= samp_pos_ff + 1'b1;
                           chan_pos_ff <= ch_cur;
                        end else if (!chunk_end) begin
                           samp_pos_ff <= '0;
                           chan_pos_ff <= ch_cur + 1'b1;
                        end else begin
                           samp_pos_ff <= '0;
                           chan_pos_ff <= '0;
                        end
                        if (chunk_end && gate_ff) begin
                           gate_ff  <= 1'b0;
                           count_ff <= cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
                        end
                        if (gate_ff) begin
                           state_ff <= ST_UPD;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_UPD: begin
               valid_ff[ch_ff] <= 1'b1;
               e_ff            <= '0;
               state_ff        <= emit_pend_ff ? ST_E_RD : ST_IDLE;
            end
            ST_E_RD:   state_ff <= ST_E_LD;
            ST_E_LD:   state_ff <= ST_E_MEAN;
            ST_E_MEAN: if (div_status.done) state_ff <= ST_E_M2;
            ST_E_M2:   if (div_status.done) state_ff <= ST_E_MUL;
            ST_E_MUL:  state_ff <= ST_E_SUM;
            ST_E_SUM:  state_ff <= ST_E_VAR;
            ST_E_VAR:  state_ff <= ST_E_OUT;
            ST_E_OUT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (e_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     e_ff     <= e_ff + 1'b1;
                     state_ff <= ST_E_RD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      // Hold the sample and its square for the update cycle
      if (req_fire) begin
         x_ff  <= x_in;
         sq_ff <= ax * ax;
      end
      if (state_ff == ST_E_LD) begin
         neg_ff <= s1_old[S1_W-1];
         s2_ff  <= s2_old;
      end
      if ((state_ff == ST_E_MEAN) && div_status.done) begin
         m_ff <= div_quo[63:0];
      end
      if ((state_ff == ST_E_M2) && div_status.done) begin
         m2_ff <= (div_quo[DIV_W-1:64] != '0) ? '1 : div_quo[63:0];
      end
      // Partial products of the mean square
      if (state_ff == ST_E_MUL) begin
         hh_ff  <= m_ff[39:16] * m_ff[39:16];
         hl_ff  <= m_ff[39:16] * m_ff[15:0];
         ll_ff  <= m_ff[15:0] * m_ff[15:0];
         big_ff <= (m_ff[63:40] != '0);
      end
      if (state_ff == ST_E_SUM) begin
         q_ff <= (big_ff || (qsum[65:64] != 2'b0)) ? '1 : qsum[63:0];
      end
      // Saturate variance to 48 bits and mean to the signed 32-bit range
      if (state_ff == ST_E_VAR) begin
         var_ff <= (vdiff[63:48] != '0) ? '1 : vdiff[47:0];
         if (neg_ff) begin
            mean_ff <= (m_ff >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - m_ff[31:0]);
         end else begin
            mean_ff <= (m_ff > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m_ff[31:0];
         end
      end
      if ((state_ff == ST_E_OUT) && rsp_free) begin
         rsp_data_ff <= {4'd0, var_ff, mean_ff, CHOUT_W'(e_ff)};
         rsp_last_ff <= e_last;
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

   `WCMV_CHECK(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr, "RAM read and write collide")
   `WCMV_CHECK(a_div_count, div_start, count_ff != '0, "divider started with zero count")
   `WCMV_CHECK_NEXT(a_last_chan, (state_ff == ST_E_OUT) && rsp_free && e_last, rsp_tvalid && rsp_tlast, "last result not flagged")

endmodule

// ===== rtl/wcmv_ram.sv =====
module wcmv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/wcmv_div.sv =====
module wcmv_div
   import wcmv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_W-1:0]     dividend,
   input  logic [CNT_W-1:0]     divisor,
   output logic [DIV_W-1:0]     quotient,
   output div_status_type       status
);

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  dsr_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W:0]    rem_sh;
   logic              fits;
   logic [CNT_W:0]    rem_in;

   // One restoring step: bring in the next dividend bit, subtract if it fits
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      fits   = rem_sh >= {1'b0, dsr_ff};
      rem_in = fits ? (rem_sh - {1'b0, dsr_ff}) : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: load operands, then shift quotient bits in
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         rem_ff <= rem_in[CNT_W-1:0];
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
